// ----- design/tbrl_pkg.sv -----
// Package: shared types and constants for the token bucket rate limiter.
`default_nettype none

package tbrl_pkg;

    localparam int unsigned TOKEN_W = 16;
    localparam int unsigned IVL_W   = 32;
    localparam int unsigned QUOT_W  = TOKEN_W + 1;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_TOKENS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS   = 2'd2;

    localparam logic [TOKEN_W-1:0] CAPACITY_RST = 16'd10;
    localparam logic [TOKEN_W-1:0] REFILL_RST   = 16'd1;
    localparam logic [IVL_W-1:0]   INTERVAL_RST = 32'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WAIT,
        ST_APPLY,
        ST_EMIT
    } tbrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // quotient saturates: bit 16 set means at least 65536
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } md_res_t;

endpackage

`default_nettype wire

// ----- design/tbrl_muldiv.sv -----
// Shift-add multiplier followed by restoring divider: floor(r * d / i), saturated.
`default_nettype none

module tbrl_muldiv
    import tbrl_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [TOKEN_W-1:0]    r,
    input  wire logic [TIME_WIDTH-1:0] d,
    input  wire logic [IVL_W-1:0]      i,
    output md_res_t                    res
);

    localparam int unsigned PW = TIME_WIDTH + TOKEN_W;
    localparam int unsigned CW = $clog2(PW + 1);

    md_state_t state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      mcand_reg, mcand_next;
    logic [TOKEN_W-1:0] mplier_reg, mplier_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [IVL_W-1:0]   div_reg, div_next;
    logic [IVL_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic               done_reg, done_next;

    logic [IVL_W:0]   trial;
    logic [IVL_W+1:0] diff;
    logic             ge;

    assign trial = {rem_reg, prod_reg[PW-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};
    assign ge    = !diff[IVL_W+1];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (start) state_next = MD_MUL;
            MD_MUL:  if (cnt_reg == CW'(TOKEN_W - 1)) state_next = MD_DIV;
            MD_DIV:  if (cnt_reg == CW'(PW - 1)) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb begin
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    mcand_next  = {{TOKEN_W{1'b0}}, d};
                    mplier_next = r;
                    prod_next   = '0;
                    div_next    = i;
                    cnt_next    = '0;
                end
            end
            MD_MUL: begin
                if (mplier_reg[0]) prod_next = prod_reg + mcand_reg;
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[TOKEN_W-1:1]};
                if (cnt_reg == CW'(TOKEN_W - 1)) begin
                    cnt_next  = '0;
                    rem_next  = '0;
                    quot_next = '0;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            MD_DIV: begin
                rem_next  = ge ? diff[IVL_W-1:0] : trial[IVL_W-1:0];
                quot_next = quot_reg[QUOT_W-1] ? quot_reg : {quot_reg[QUOT_W-2:0], ge};
                prod_next = {prod_reg[PW-2:0], 1'b0};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PW - 1)) done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

`default_nettype wire

// ----- design/token_bucket_rate_limiter.sv -----
// Token bucket rate limiter top level: stream ports, config registers, bucket state.
// After acceptance a request covered by the stock goes EVAL, EMIT; a denial without a refill
// goes EVAL, APPLY, EMIT; a refill goes EVAL, WAIT, APPLY, EMIT, with 16 multiply steps and
// TIME_WIDTH + 16 divide steps on the shared unit. One request in work at a time; the next
// is accepted in the cycle in which the result goes valid, later if the result is stalled.
// Synchronous active-low reset: stock and last refill time to 0, registers to defaults.
`default_nettype none

module token_bucket_rate_limiter
    import tbrl_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] request_tokens, [TIME_WIDTH+15:16] now_ms, zero pad
    input  wire logic [((TOKEN_W+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] granted, [16:1] tokens_left, zero pad
    output logic [23:0]                 m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [IVL_W-1:0]       cfg_data
);

    tbrl_state_t state_reg, state_next;

    logic [TOKEN_W-1:0]    cap_reg, refill_reg;
    logic [IVL_W-1:0]      ivl_reg;
    logic [TOKEN_W-1:0]    avail_reg, avail_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [TOKEN_W-1:0]    req_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic                  res_grant_reg, res_grant_next;
    logic [TOKEN_W-1:0]    res_left_reg, res_left_next;
    logic                  m_valid_reg;
    logic                  out_grant_reg;
    logic [TOKEN_W-1:0]    out_left_reg;

    logic                  s_fire, out_free, fast_ok, refill_ok, md_start;
    logic [TOKEN_W-1:0]    capped, filled;
    logic [TOKEN_W:0]      sum;
    md_res_t               md_res;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign fast_ok  = req_reg <= avail_reg;
    assign refill_ok = (now_reg > last_reg) && (ivl_reg != '0) && (refill_reg != '0);

    assign capped = (q_reg > {1'b0, cap_reg}) ? cap_reg : q_reg[TOKEN_W-1:0];
    assign sum    = {1'b0, avail_reg} + {1'b0, capped};
    assign filled = (sum > {1'b0, cap_reg}) ? cap_reg : sum[TOKEN_W-1:0];

    tbrl_muldiv #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (md_start),
        .r      (refill_reg),
        .d      (now_reg - last_reg),
        .i      (ivl_reg),
        .res    (md_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_EVAL;
            ST_EVAL: begin
                priority if (fast_ok) state_next = ST_EMIT;
                else if (refill_ok)   state_next = ST_WAIT;
                else                  state_next = ST_APPLY;
            end
            ST_WAIT:  if (md_res.done) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        md_start  = (state_reg == ST_EVAL) && !fast_ok && refill_ok;
    end

    always_comb begin
        avail_next     = avail_reg;
        last_next      = last_reg;
        q_next         = q_reg;
        res_grant_next = res_grant_reg;
        res_left_next  = res_left_reg;
        unique case (state_reg)
            ST_EVAL: begin
                q_next = '0;
                if (fast_ok) begin
                    avail_next     = avail_reg - req_reg;
                    res_grant_next = 1'b1;
                    res_left_next  = avail_reg - req_reg;
                end
            end
            ST_WAIT: if (md_res.done) q_next = md_res.quot;
            ST_APPLY: begin
                if (q_reg != '0) last_next = now_reg;
                if (req_reg <= filled) begin
                    avail_next     = filled - req_reg;
                    res_grant_next = 1'b1;
                    res_left_next  = filled - req_reg;
                end else begin
                    avail_next     = filled;
                    res_grant_next = 1'b0;
                    res_left_next  = filled;
                end
            end
            ST_IDLE, ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAPACITY_RST;
            refill_reg  <= REFILL_RST;
            ivl_reg     <= INTERVAL_RST;
            avail_reg   <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            avail_reg <= avail_next;
            last_reg  <= last_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CAPACITY:      cap_reg    <= cfg_data[TOKEN_W-1:0];
                    CFG_REFILL_TOKENS: refill_reg <= cfg_data[TOKEN_W-1:0];
                    CFG_INTERVAL_MS:   ivl_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            req_reg <= s_tdata[TOKEN_W-1:0];
            now_reg <= s_tdata[TOKEN_W+TIME_WIDTH-1:TOKEN_W];
        end
        q_reg         <= q_next;
        res_grant_reg <= res_grant_next;
        res_left_reg  <= res_left_next;
        if (state_reg == ST_EMIT && out_free) begin
            out_grant_reg <= res_grant_reg;
            out_left_reg  <= res_left_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_left_reg, out_grant_reg};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_EVAL))
        else $error("request accepted but sequencer did not start");

    a_muldiv_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_res.done |-> (state_reg == ST_WAIT))
        else $error("refill result arrived outside wait state");

    a_stock_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && (state_reg == ST_IDLE || state_reg == ST_WAIT)) |=> $stable(avail_reg))
        else $error("token stock changed while no request in update");

    a_last_moves_on_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && (last_reg != last_next)) |-> (state_reg == ST_APPLY && q_reg != '0))
        else $error("last refill time moved without a refill");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for token_bucket_rate_limiter: directed and random requests, bucket predictor.
module testbench;
    import tbrl_pkg::*;

    localparam int TIME_W = 48;
    localparam int DATA_W = ((TOKEN_W + TIME_W + 7) / 8) * 8;
    localparam logic [63:0] TIME_CEIL = 64'h0000_4000_0000_0000;

    typedef struct packed {
        logic              granted;
        logic [TOKEN_W-1:0] left;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
    logic [IVL_W-1:0]      cfg_data = '0;

    // bucket predictor state
    logic [TOKEN_W-1:0]    cap_reg = CAPACITY_RST;
    logic [TOKEN_W-1:0]    refill_reg = REFILL_RST;
    logic [IVL_W-1:0]      ivl_reg = INTERVAL_RST;
    logic [TOKEN_W-1:0]    stock = '0;
    logic [TIME_W-1:0]     last_refill_ms = '0;

    logic [DATA_W-1:0]     pending[$];
    verdict_t              verdicts[$];
    logic [63:0]           t_ms = 0;
    int                    queued = 0;
    int                    accepted = 0;
    int                    grants = 0;
    int                    denials = 0;
    int                    settings = 0;
    int                    errors = 0;
    int                    burst_left = 1;
    int                    gap_left = 0;
    int                    rdy_mode = 0;
    int                    rdy_left = 0;

    token_bucket_rate_limiter #(.TIME_WIDTH(TIME_W)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // floor(r * d / i), saturating the whole-interval part near 2^32
    function automatic logic [63:0] refill_amount(input logic [63:0] r, input logic [63:0] d,
                                                  input logic [63:0] i);
        logic [63:0] whole;
        logic [63:0] rest;
        logic [63:0] head;
        whole = d / i;
        rest = ((d % i) * r) / i;
        if (whole >= 64'h1_0000_0000) begin
            head = (r != 0) ? 64'h1_0000_0000 : 64'd0;
        end else begin
            head = whole * r;
        end
        return head + rest;
    endfunction

    task automatic bucket_step(input logic [TOKEN_W-1:0] req, input logic [TIME_W-1:0] now);
        logic [63:0] fill;
        logic [63:0] total;
        verdict_t    v;
        v.granted = 1'b0;
        if (req <= stock) begin
            stock = stock - req;
            v.granted = 1'b1;
        end else begin
            fill = 0;
            if (now > last_refill_ms && ivl_reg != 0) begin
                fill = refill_amount({48'd0, refill_reg}, {16'd0, now - last_refill_ms},
                                     {32'd0, ivl_reg});
            end
            if (fill != 0) begin
                last_refill_ms = now;
            end
            if (fill > {48'd0, cap_reg}) begin
                fill = {48'd0, cap_reg};
            end
            total = {48'd0, stock} + fill;
            stock = (total > {48'd0, cap_reg}) ? cap_reg : total[TOKEN_W-1:0];
            if (req <= stock) begin
                stock = stock - req;
                v.granted = 1'b1;
            end
        end
        v.left = stock;
        verdicts.push_back(v);
    endtask

    // request driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                bucket_step(s_tdata[TOKEN_W-1:0], s_tdata[TOKEN_W+TIME_W-1:TOKEN_W]);
                accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                s_tdata <= pending.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                    end else begin
                        gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 4);
                    end
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(16, 300);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rdy_left % 8) < 3;
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                v = verdicts.pop_front();
                if (m_tdata[0] !== v.granted) begin
                    $display("%0t: granted expected %0d actual %0d", $time, v.granted, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[16:1] !== v.left) begin
                    $display("%0t: tokens_left expected %0d actual %0d", $time, v.left,
                             m_tdata[16:1]);
                    errors++;
                end
                if (v.granted) begin
                    grants++;
                end else begin
                    denials++;
                end
            end
        end
    end

    task automatic queue_request(input logic [TOKEN_W-1:0] req, input logic [63:0] now);
        pending.push_back({now[TIME_W-1:0], req});
        queued++;
    endtask

    task automatic drain();
        while (accepted != queued || verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CAPACITY:      cap_reg = data[TOKEN_W-1:0];
            CFG_REFILL_TOKENS: refill_reg = data[TOKEN_W-1:0];
            CFG_INTERVAL_MS:   ivl_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [TOKEN_W-1:0] c, input logic [TOKEN_W-1:0] r,
                              input logic [IVL_W-1:0] i);
        drain();
        write_reg(CFG_CAPACITY, {16'd0, c});
        write_reg(CFG_REFILL_TOKENS, {16'd0, r});
        write_reg(CFG_INTERVAL_MS, i);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic random_requests(input int n);
        logic [63:0]        iv;
        logic [63:0]        delta;
        logic [63:0]        now;
        logic [TOKEN_W-1:0] cap;
        logic [TOKEN_W-1:0] req;
        int                 k;
        int                 m;
        int                 r;
        iv = (ivl_reg == 0) ? 64'd1000 : {32'd0, ivl_reg};
        cap = (cap_reg == 0) ? 16'd1 : cap_reg;
        for (k = 0; k < n; k++) begin
            m = $urandom_range(0, 9);
            case (m)
                0, 1:    delta = 64'($urandom_range(0, 3));
                2, 3, 4: delta = {$urandom, $urandom} % iv;
                5, 6:    delta = iv * 64'($urandom_range(1, 3)) + {$urandom, $urandom} % iv;
                7:       delta = {32'd0, $urandom};
                default: delta = 0;
            endcase
            if (t_ms + delta < TIME_CEIL) begin
                t_ms = t_ms + delta;
            end
            now = t_ms;
            if (m == 8) begin
                now = t_ms - ({$urandom, $urandom} % (t_ms + 1));
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                req = 0;
            end else if (r < 4) begin
                req = 16'($urandom);
            end else if (r < 10) begin
                req = 16'($urandom_range(1, 4));
            end else begin
                req = 16'($urandom_range(1, cap));
            end
            queue_request(req, now);
        end
    endtask

    task automatic random_setting();
        logic [TOKEN_W-1:0] c;
        logic [TOKEN_W-1:0] r;
        logic [IVL_W-1:0]   i;
        case ($urandom_range(0, 3))
            0: c = 1;
            1: c = 16'hFFFF;
            2: c = 16'($urandom_range(1, 64));
            default: c = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: r = 0;
            1: r = 1;
            2, 3: r = 16'($urandom_range(1, 16));
            4: r = 16'hFFFF;
            default: r = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: i = 1;
            1: i = $urandom_range(1, 2000);
            2: i = 32'hFFFF_FFFF;
            default: i = $urandom;
        endcase
        set_limits(c, r, i);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset
        queue_request(0, 0);
        queue_request(1, 0);
        queue_request(1, 999);
        queue_request(1, 1000);
        queue_request(16'hFFFF, 9000);
        queue_request(8, 9000);
        queue_request(3, 500);
        // saturating refill
        set_limits(16'hFFFF, 16'hFFFF, 1);
        queue_request(16'hFFFF, 9001);
        queue_request(16'hFFFF, 9001);
        // zero interval
        set_limits(16'hFFFF, 16'hFFFF, 0);
        queue_request(1, 20000);
        // no refill, top timestamp leaves the refill time alone
        set_limits(16'hFFFF, 0, 1);
        queue_request(1, 64'h0000_FFFF_FFFF_FFFF);
        set_limits(100, 7, 3);
        queue_request(100, 9031);
        queue_request(50, 9031);
        // lowered capacity
        set_limits(5, 7, 3);
        queue_request(10, 9031);
        queue_request(11, 9031);
        // zero capacity
        set_limits(0, 7, 3);
        queue_request(1, 9040);
        queue_request(0, 9040);
        t_ms = 9040;

        repeat (10) begin
            random_setting();
            random_requests(132);
        end

        // time at the top of the range
        set_limits(16'hFFFF, 16'hFFFF, 1);
        queue_request(16'hFFFF, 64'h0000_FFFF_FFFF_FFFF);
        queue_request(1, 64'h0000_FFFF_FFFF_FFFE);
        set_limits(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(1, 64'h0000_FFFF_FFFF_FFFF);

        drain();
        repeat (20) @(posedge aclk);
        if (verdicts.size() != 0) begin
            errors++;
        end
        $display("Checked %0d requests across %0d register settings: %0d granted, %0d denied",
                 accepted, settings, grants, denials);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
